@@ rtl/vrct_pkg.sv @@
// Shared types and constants for the view ray crossing test block.
// Used by vrct_div and view_ray_crossing_test_unit; no dependencies.
package vrct_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] REG_SINE     = 2'd2;
    localparam logic [1:0] REG_COSINE   = 2'd3;

    // Half width of the band around the ray in which a point counts as hit
    localparam logic signed [31:0] POINT_REACH = 32'sh0014_0001;

    // Quotient bits of the crossing fraction (fraction is at most 1.0 in 16.16)
    localparam int QUO_W = 17;

    // Beat carried through the divider stages
    typedef struct packed {
        logic                is_point;
        logic                pt_hit;
        logic                seg_cross;
        logic                side1;
        logic signed [31:0]  tz1;
        logic signed [32:0]  dz;
        logic [32:0]         den;
        logic [33:0]         rem;
        logic [QUO_W-1:0]    quo;
    } vrct_item_t;

endpackage

@@ rtl/vrct_div.sv @@
// Pipelined restoring divider for the crossing fraction, one quotient bit per stage.
// Depends on vrct_pkg (vrct_item_t, QUO_W).
module vrct_div
    import vrct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_vld,
    input  vrct_item_t in_item,
    output logic       out_vld,
    output vrct_item_t out_item
);

    vrct_item_t stg_reg [QUO_W];
    logic       vld_reg [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_stage
            vrct_item_t src;
            vrct_item_t stg_next;
            logic       src_vld;
            logic [33:0] trial;
            logic        ge;

            if (k == 0)
            begin : g_first
                assign src     = in_item;
                assign src_vld = in_vld;
                // first bit: fraction is exactly one when numerator equals denominator
                assign trial   = src.rem;
            end
            else
            begin : g_rest
                assign src     = stg_reg[k-1];
                assign src_vld = vld_reg[k-1];
                assign trial   = {src.rem[32:0], 1'b0};
            end

            // compare and subtract, shift in one quotient bit
            always_comb
            begin
                ge           = (trial >= {1'b0, src.den});
                stg_next     = src;
                stg_next.rem = ge ? (trial - {1'b0, src.den}) : trial;
                stg_next.quo = {src.quo[QUO_W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= src_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    stg_reg[k] <= stg_next;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[QUO_W-1];
    assign out_item = stg_reg[QUO_W-1];

endmodule

@@ rtl/view_ray_crossing_test_unit.sv @@
// Each input beat passes stages 1 to 4, the divider, stage 5 and the output register.
// Throughput: one beat per cycle while the skid is empty; 17 divider stages set the depth, one bit each.
// A two-entry output (register plus skid) keeps input accepted while one result waits, not while two do.
// Reset: asynchronous, active low; clears valids, ray origin 0, sine 0, cosine 1.0.
// Depends on vrct_pkg and vrct_div.
module view_ray_crossing_test_unit
    import vrct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic               two_sided,
    input  logic               check_all,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic signed [31:0] depth,
    output logic               cross_side
);

    typedef struct packed {
        logic mode;
        logic two_sided;
        logic check_all;
    } vrct_flags_t;

    // Ray registers
    logic signed [31:0] org_x_reg, org_y_reg;
    logic signed [17:0] sin_reg, cos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            sin_reg   <= '0;
            cos_reg   <= 18'sd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: org_x_reg <= cfg_data;
                REG_ORIGIN_Y: org_y_reg <= cfg_data;
                REG_SINE:     sin_reg   <= cfg_data[17:0];
                REG_COSINE:   cos_reg   <= cfg_data[17:0];
                default:      ;
            endcase
        end
    end

    logic en;
    logic skid_vld_reg;
    assign en       = !skid_vld_reg;
    assign in_ready = en;

    // Stage 1: offsets from the ray origin
    logic               s1_vld_reg;
    vrct_flags_t        s1_flg_reg;
    logic signed [31:0] gx1_reg, gy1_reg, gx2_reg, gy2_reg;

    // Stage 2: rotation products, shifted by 16 and wrapped to 32 bits
    logic               s2_vld_reg;
    vrct_flags_t        s2_flg_reg;
    logic signed [31:0] p_x1s_reg, p_y1c_reg, p_x1c_reg, p_y1s_reg;
    logic signed [31:0] p_x2s_reg, p_y2c_reg, p_x2c_reg, p_y2s_reg;
    logic signed [49:0] m_x1s, m_y1c, m_x1c, m_y1s, m_x2s, m_y2c, m_x2c, m_y2s;

    // Stage 3: view-space coordinates
    logic               s3_vld_reg;
    vrct_flags_t        s3_flg_reg;
    logic signed [31:0] tx1_reg, tz1_reg, tx2_reg, tz2_reg;

    // Stage 4: classify, set up division
    logic               s4_vld_reg;
    vrct_item_t         s4_reg, s4_next;

    assign m_x1s = gx1_reg * sin_reg;
    assign m_y1c = gy1_reg * cos_reg;
    assign m_x1c = gx1_reg * cos_reg;
    assign m_y1s = gy1_reg * sin_reg;
    assign m_x2s = gx2_reg * sin_reg;
    assign m_y2c = gy2_reg * cos_reg;
    assign m_x2c = gx2_reg * cos_reg;
    assign m_y2s = gy2_reg * sin_reg;

    // Classify the crossing and load the divider operands
    always_comb
    begin
        logic signed [32:0] tx1e;
        logic signed [32:0] tx2e;
        logic               c0;
        logic               c1;
        logic               seg_on;
        logic signed [32:0] num;
        tx1e   = {tx1_reg[31], tx1_reg};
        tx2e   = {tx2_reg[31], tx2_reg};
        c0     = (tx1_reg < 32'sd1) && (tx2_reg > 32'sd0);
        c1     = (tx1_reg >= 32'sd1) && (tx2_reg <= 32'sd0) && s3_flg_reg.two_sided;
        seg_on = !s3_flg_reg.mode && (s3_flg_reg.check_all || s3_flg_reg.two_sided);
        num    = c1 ? tx1e : -tx1e;
        s4_next.is_point  = s3_flg_reg.mode;
        s4_next.pt_hit    = s3_flg_reg.mode && s3_flg_reg.check_all
                            && (tz1_reg > 32'sd0)
                            && (tx1_reg > -POINT_REACH) && (tx1_reg < POINT_REACH);
        s4_next.seg_cross = seg_on && (c0 || c1);
        s4_next.side1     = c1;
        s4_next.tz1       = tz1_reg;
        s4_next.dz        = {tz2_reg[31], tz2_reg} - {tz1_reg[31], tz1_reg};
        s4_next.den       = c1 ? 33'(tx1e - tx2e) : 33'(tx2e - tx1e);
        s4_next.rem       = {1'b0, num};
        s4_next.quo       = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // Advance the front stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_flg_reg <= '{mode: mode, two_sided: two_sided, check_all: check_all};
            gx1_reg    <= start_x - org_x_reg;
            gy1_reg    <= start_y - org_y_reg;
            gx2_reg    <= end_x - org_x_reg;
            gy2_reg    <= end_y - org_y_reg;

            s2_flg_reg <= s1_flg_reg;
            p_x1s_reg  <= m_x1s[47:16];
            p_y1c_reg  <= m_y1c[47:16];
            p_x1c_reg  <= m_x1c[47:16];
            p_y1s_reg  <= m_y1s[47:16];
            p_x2s_reg  <= m_x2s[47:16];
            p_y2c_reg  <= m_y2c[47:16];
            p_x2c_reg  <= m_x2c[47:16];
            p_y2s_reg  <= m_y2s[47:16];

            s3_flg_reg <= s2_flg_reg;
            tx1_reg    <= p_x1s_reg - p_y1c_reg;
            tz1_reg    <= p_x1c_reg + p_y1s_reg;
            tx2_reg    <= p_x2s_reg - p_y2c_reg;
            tz2_reg    <= p_x2c_reg + p_y2s_reg;

            s4_reg     <= s4_next;
        end
    end

    // Divider
    logic       dv_vld;
    vrct_item_t dv_item;

    vrct_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s4_vld_reg),
        .in_item  (s4_reg),
        .out_vld  (dv_vld),
        .out_item (dv_item)
    );

    // Stage 5: interpolate depth product
    logic               s5_vld_reg;
    vrct_item_t         s5_reg;
    logic signed [34:0] s5_prod_reg;
    logic signed [50:0] m_dz;

    assign m_dz = dv_item.dz * $signed({1'b0, dv_item.quo});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg      <= dv_item;
            s5_prod_reg <= m_dz[50:16];
        end
    end

    // Form the result beat
    logic               r_hit, r_side;
    logic signed [31:0] r_depth;
    logic signed [34:0] z;

    always_comb
    begin
        z = {{3{s5_reg.tz1[31]}}, s5_reg.tz1} + s5_prod_reg;
        if (s5_reg.is_point)
        begin
            r_hit   = s5_reg.pt_hit;
            r_depth = s5_reg.pt_hit ? s5_reg.tz1 : 32'sd0;
            r_side  = 1'b0;
        end
        else
        begin
            r_hit   = s5_reg.seg_cross && !z[34];
            r_depth = r_hit ? z[31:0] : 32'sd0;
            r_side  = r_hit && s5_reg.side1;
        end
    end

    // Output register with skid entry
    logic               leave;
    logic               out_vld_reg;
    logic               o_hit_reg, o_side_reg, k_hit_reg, k_side_reg;
    logic signed [31:0] o_depth_reg, k_depth_reg;

    assign leave = s5_vld_reg && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || out_ready)
        begin
            out_vld_reg  <= skid_vld_reg || leave;
            skid_vld_reg <= 1'b0;
        end
        else if (leave)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || out_ready)
        begin
            if (skid_vld_reg)
            begin
                o_hit_reg   <= k_hit_reg;
                o_depth_reg <= k_depth_reg;
                o_side_reg  <= k_side_reg;
            end
            else
            begin
                o_hit_reg   <= r_hit;
                o_depth_reg <= r_depth;
                o_side_reg  <= r_side;
            end
        end
        else if (leave)
        begin
            k_hit_reg   <= r_hit;
            k_depth_reg <= r_depth;
            k_side_reg  <= r_side;
        end
    end

    assign out_valid  = out_vld_reg;
    assign hit        = o_hit_reg;
    assign depth      = o_depth_reg;
    assign cross_side = o_side_reg;

endmodule

@@ tb/tb_view_ray_crossing_test_unit.sv @@
`timescale 1ns / 100ps
// Testbench for view_ray_crossing_test_unit: drives segments and points through a
// valid/ready channel and compares every result beat with an in-bench predictor.
// Depends on vrct_pkg and the block's RTL.
module tb_view_ray_crossing_test_unit;
    import vrct_pkg::*;

    typedef struct {
        logic        mode;
        logic [31:0] sx, sy, ex, ey;
        logic        two_sided, check_all;
    } probe_t;

    typedef struct {
        logic        hit;
        logic [31:0] depth;
        logic        side;
    } ray_result_t;

    logic               clk, rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid, in_ready;
    logic               mode, two_sided, check_all;
    logic signed [31:0] start_x, start_y, end_x, end_y;
    logic               out_valid, out_ready;
    logic               hit, cross_side;
    logic signed [31:0] depth;

    // Predictor copy of the ray registers
    longint ray_ox, ray_oy, ray_sin, ray_cos;

    probe_t      pending_probes[$];
    ray_result_t expected_crossings[$];
    int          errors, results_seen, probes_sent;
    int          send_idle_pct, recv_stall_pct, hold_off_cycles;

    view_ray_crossing_test_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("timeout at %0t", $time);
        $display("tb_view_ray_crossing_test_unit NOT OK");
        $finish;
    end

    function automatic longint wrap32(longint v);
        logic [31:0] t;
        t = v[31:0];
        return longint'(signed'(t));
    endfunction

    // Product shifted right by 16 rounding toward minus infinity
    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic void rotate_to_ray(input longint x, input longint y,
                                          output longint tx, output longint tz);
        longint gx, gy;
        gx = wrap32(x - ray_ox);
        gy = wrap32(y - ray_oy);
        tx = wrap32(fx_mul(gx, ray_sin) - fx_mul(gy, ray_cos));
        tz = wrap32(fx_mul(gx, ray_cos) + fx_mul(gy, ray_sin));
    endfunction

    function automatic ray_result_t predict_crossing(probe_t p);
        ray_result_t r;
        longint      tx1, tz1, tx2, tz2, frac, span, z;
        logic        crossed, side;
        r.hit = 1'b0; r.depth = '0; r.side = 1'b0;
        side = 1'b0;
        if (p.mode) begin
            if (p.check_all) begin
                rotate_to_ray(longint'(signed'(p.sx)), longint'(signed'(p.sy)), tx1, tz1);
                if (tz1 > 0 && tx1 > -longint'(POINT_REACH) && tx1 < longint'(POINT_REACH))
                begin
                    r.hit = 1'b1;
                    r.depth = tz1[31:0];
                end
            end
        end else if (p.check_all || p.two_sided) begin
            rotate_to_ray(longint'(signed'(p.sx)), longint'(signed'(p.sy)), tx1, tz1);
            rotate_to_ray(longint'(signed'(p.ex)), longint'(signed'(p.ey)), tx2, tz2);
            crossed = 1'b1;
            frac = 0;
            if (tx1 < 1 && tx2 > 0) begin
                span = tx2 - tx1;
                frac = (span > 0) ? ((-tx1) * 65536) / span : 0;
            end else if (tx1 >= 1 && tx2 <= 0 && p.two_sided) begin
                span = tx1 - tx2;
                frac = (span > 0) ? (tx1 * 65536) / span : 0;
                side = 1'b1;
            end else begin
                crossed = 1'b0;
            end
            if (crossed) begin
                z = tz1 + fx_mul(tz2 - tz1, frac);
                if (z > -1) begin
                    r.hit = 1'b1;
                    r.depth = z[31:0];
                    r.side = side;
                end
            end
        end
        return r;
    endfunction

    // Driver: offer the head of the pending queue, advance on each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_crossings.push_back(predict_crossing(pending_probes.pop_front()));
                probes_sent++;
            end
            if ((!in_valid || in_ready) && pending_probes.size() > 0
                && (in_valid && in_ready ? pending_probes.size() > 0 : 1'b1)) begin
                if ($urandom_range(99) >= send_idle_pct) begin
                    in_valid  <= 1'b1;
                    mode      <= pending_probes[0].mode;
                    start_x   <= pending_probes[0].sx;
                    start_y   <= pending_probes[0].sy;
                    end_x     <= pending_probes[0].ex;
                    end_y     <= pending_probes[0].ey;
                    two_sided <= pending_probes[0].two_sided;
                    check_all <= pending_probes[0].check_all;
                end else begin
                    in_valid <= 1'b0;
                end
            end else if (in_valid && in_ready) begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, or held off for a long stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        ray_result_t want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (expected_crossings.size() == 0) begin
                $display("%0t: unexpected beat hit=%0b depth=%h side=%0b",
                         $time, hit, depth, cross_side);
                errors++;
            end else begin
                want = expected_crossings.pop_front();
                if (want.hit !== hit || want.depth !== depth || want.side !== cross_side)
                begin
                    $display("%0t: expected hit=%0b depth=%h side=%0b, got %0b %h %0b",
                             $time, want.hit, want.depth, want.side,
                             hit, depth, cross_side);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ORIGIN_X: ray_ox  = longint'(signed'(val));
            REG_ORIGIN_Y: ray_oy  = longint'(signed'(val));
            REG_SINE:     ray_sin = longint'(signed'(val[17:0]));
            default:      ray_cos = longint'(signed'(val[17:0]));
        endcase
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_probes.size() > 0 || in_valid || expected_crossings.size() > 0)
               && guard < 2000000) begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
    endtask

    task automatic add_probe(logic m, logic [31:0] a, logic [31:0] b,
                             logic [31:0] c, logic [31:0] d, logic ts, logic ca);
        probe_t p;
        p.mode = m; p.sx = a; p.sy = b; p.ex = c; p.ey = d;
        p.two_sided = ts; p.check_all = ca;
        pending_probes.push_back(p);
    endtask

    // Random coordinate: mostly near the ray, sometimes full range
    function automatic logic [31:0] rand_coord(longint centre);
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'(centre + $signed($urandom_range(32'h0040_0000)) -
                                32'sh0020_0000);
        endcase
    endfunction

    task automatic add_random_probe();
        logic [31:0] a, b, c, d;
        a = rand_coord(ray_ox + 2 * ray_cos);  b = rand_coord(ray_oy + 2 * ray_sin);
        c = rand_coord(ray_ox + 2 * ray_cos);  d = rand_coord(ray_oy + 2 * ray_sin);
        add_probe($urandom_range(3) == 0, a, b, c, d, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    endtask

    initial
    begin
        int          phase;
        logic [31:0] sin_cos [4][2];
        errors = 0; results_seen = 0; probes_sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
        cfg_we = 1'b0; cfg_index = REG_ORIGIN_X; cfg_data = '0;
        mode = 1'b0; start_x = '0; start_y = '0; end_x = '0; end_y = '0;
        two_sided = 1'b0; check_all = 1'b0;
        ray_ox = 0; ray_oy = 0; ray_sin = 0; ray_cos = 65536;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset ray along +x; crossings, sides, points, extremes
        add_probe(0, 32'h0005_0000, 32'h0001_0000, 32'h0005_0000, 32'hffff_0000, 1, 0);
        add_probe(0, 32'h0005_0000, 32'hffff_0000, 32'h0005_0000, 32'h0001_0000, 1, 1);
        add_probe(0, 32'h0005_0000, 32'hffff_0000, 32'h0005_0000, 32'h0001_0000, 0, 1);
        add_probe(0, 32'h0005_0000, 32'h0001_0000, 32'h0005_0000, 32'hffff_0000, 0, 1);
        add_probe(0, 32'h0005_0000, 32'h0001_0000, 32'h0005_0000, 32'hffff_0000, 0, 0);
        add_probe(0, 32'hfffb_0000, 32'h0001_0000, 32'hfffb_0000, 32'hffff_0000, 1, 1);
        add_probe(0, 32'h0005_0000, 32'h0000_0000, 32'h0005_0000, 32'h0000_0000, 1, 1);
        add_probe(1, 32'h0003_0000, 32'h0014_0000, 0, 0, 0, 1);
        add_probe(1, 32'h0003_0000, 32'h0014_0001, 0, 0, 0, 1);
        add_probe(1, 32'h0003_0000, 32'hffec_0000, 0, 0, 0, 1);
        add_probe(1, 32'h0003_0000, 32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 1, 0);
        add_probe(1, 32'hfffd_0000, 32'h0000_0000, 0, 0, 0, 1);
        add_probe(1, 32'h0000_0000, 32'h0000_0000, 0, 0, 1, 1);
        add_probe(0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1, 1);
        add_probe(0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1, 1);
        add_probe(1, 32'h7fff_ffff, 32'h0000_0000, 0, 0, 1, 1);
        add_probe(0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1);
        drain();

        // Ray settings: along +y, a diagonal, along -y and out-of-range values; extreme origin last
        sin_cos[0] = '{32'h0001_0000, 32'h0000_0000};
        sin_cos[1] = '{32'h0000_b505, 32'hffff_4afb};
        sin_cos[2] = '{32'hffff_0000, 32'h0000_0000};
        sin_cos[3] = '{32'h0001_ffff, 32'h0002_0000};
        for (phase = 0; phase < 8; phase++) begin
            write_reg(REG_ORIGIN_X, (phase == 7) ? 32'h7fff_0000 : $urandom);
            write_reg(REG_ORIGIN_Y, (phase == 7) ? 32'h8000_0000 : $urandom);
            write_reg(REG_SINE,   sin_cos[phase % 4][0]);
            write_reg(REG_COSINE, sin_cos[phase % 4][1]);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            repeat (215) add_random_probe();
            if (phase == 0) hold_off_cycles = 300;
            drain();
        end

        // Every accepted beat must have come back
        if (pending_probes.size() != 0 || expected_crossings.size() != 0
            || results_seen != probes_sent) begin
            $display("%0t: expected %0d results, got %0d (%0d beats still queued)",
                     $time, probes_sent, results_seen, pending_probes.size());
            errors++;
        end

        $display("%0d segment and point beats sent, %0d results checked over 8 ray settings",
                 probes_sent, results_seen);
        if (errors == 0)
            $display("tb_view_ray_crossing_test_unit OK");
        else
            $display("tb_view_ray_crossing_test_unit NOT OK");
        $finish;
    end

endmodule

@@ view_ray_crossing_test_unit.f @@
rtl/vrct_pkg.sv
rtl/vrct_div.sv
rtl/view_ray_crossing_test_unit.sv
tb/tb_view_ray_crossing_test_unit.sv
